/* src/clas_pkg.sv */
// ----------------------------------------------------------------------------
// clas_pkg
// Shared types and constants for the command line argument splitter: the
// byte codes it recognises and the command passed from the front to the back.
// ----------------------------------------------------------------------------
package clas_pkg;

  localparam int MAX_BACKSLASH_RUN = 63;
  localparam int RUN_W = $clog2(MAX_BACKSLASH_RUN + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // what follows the backslash run of a command
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_CHAR = 2'd1,
    TAIL_END  = 2'd2
  } tail_t;

  typedef struct packed {
    logic [RUN_W-1:0] bs_count;
    tail_t            tail;
    logic [7:0]       tail_char;
    logic             overflow;
  } cmd_t;

endpackage

/* src/clas_front.sv */
// ----------------------------------------------------------------------------
// clas_front
// Accepts command line bytes, tracks argument, quoting and backslash-run
// state, and turns bytes into commands for the back.
// ----------------------------------------------------------------------------
module clas_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_in,
  input  logic                 line_end,
  input  logic                 full,
  output logic                 push,
  output clas_pkg::cmd_t       push_cmd
);

  logic                       inside_argument;
  logic                       quoting;
  logic [clas_pkg::RUN_W-1:0] pending;
  logic                       saturated;

  logic                       inside_argument_next;
  logic                       quoting_next;
  logic [clas_pkg::RUN_W-1:0] pending_next;
  logic                       saturated_next;
  logic                       emit;

  logic                       accept;
  logic                       is_sep;
  logic [clas_pkg::RUN_W-1:0] held;
  logic                       held_sat;
  logic                       quoting_eff;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign is_sep   = (char_in == clas_pkg::CH_SPACE) || (char_in == clas_pkg::CH_TAB);

  // a new argument starts from clean state
  assign held        = inside_argument ? pending : '0;
  assign held_sat    = inside_argument ? saturated : 1'b0;
  assign quoting_eff = inside_argument ? quoting : 1'b0;

  always_comb begin
    inside_argument_next = inside_argument;
    quoting_next         = quoting;
    pending_next         = pending;
    saturated_next       = saturated;
    emit                 = 1'b0;
    push_cmd.bs_count    = held;
    push_cmd.tail        = clas_pkg::TAIL_NONE;
    push_cmd.tail_char   = 8'h00;
    push_cmd.overflow    = held_sat;
    priority if (line_end) begin
      emit                 = inside_argument;
      push_cmd.tail        = clas_pkg::TAIL_END;
      inside_argument_next = 1'b0;
      quoting_next         = 1'b0;
      pending_next         = '0;
      saturated_next       = 1'b0;
    end else if (!inside_argument && is_sep) begin
      emit = 1'b0;
    end else if (char_in == clas_pkg::CH_BSLASH) begin
      inside_argument_next = 1'b1;
      quoting_next         = quoting_eff;
      if (held < clas_pkg::RUN_W'(clas_pkg::MAX_BACKSLASH_RUN)) begin
        pending_next   = held + 1'b1;
        saturated_next = held_sat;
      end else begin
        pending_next   = held;
        saturated_next = 1'b1;
      end
    end else if (char_in == clas_pkg::CH_QUOTE) begin
      inside_argument_next = 1'b1;
      pending_next         = '0;
      saturated_next       = 1'b0;
      push_cmd.bs_count    = held >> 1;
      if (held[0]) begin
        push_cmd.tail      = clas_pkg::TAIL_CHAR;
        push_cmd.tail_char = clas_pkg::CH_QUOTE;
        quoting_next       = quoting_eff;
      end else begin
        quoting_next = !quoting_eff;
      end
      // an even run of zero before a quote gives nothing
      emit = held[0] || (held > clas_pkg::RUN_W'(1));
    end else begin
      pending_next   = '0;
      saturated_next = 1'b0;
      emit           = 1'b1;
      if (!quoting_eff && is_sep) begin
        push_cmd.tail        = clas_pkg::TAIL_END;
        inside_argument_next = 1'b0;
        quoting_next         = 1'b0;
      end else begin
        push_cmd.tail        = clas_pkg::TAIL_CHAR;
        push_cmd.tail_char   = char_in;
        inside_argument_next = 1'b1;
        quoting_next         = quoting_eff;
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_argument <= 1'b0;
      quoting         <= 1'b0;
      pending         <= '0;
      saturated       <= 1'b0;
    end else if (accept) begin
      inside_argument <= inside_argument_next;
      quoting         <= quoting_next;
      pending         <= pending_next;
      saturated       <= saturated_next;
    end
  end

endmodule

/* src/clas_queue.sv */
// ----------------------------------------------------------------------------
// clas_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module clas_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clas_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output clas_pkg::cmd_t head,
  output logic           not_empty
);

  localparam int PTR_W = (clas_pkg::QUEUE_DEPTH > 1) ? $clog2(clas_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(clas_pkg::QUEUE_DEPTH + 1);

  clas_pkg::cmd_t   entries [clas_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(clas_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(clas_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/clas_back.sv */
// ----------------------------------------------------------------------------
// clas_back
// Carries out queued commands: emits the backslash run one byte a cycle
// unless stalled, then any tail byte or end marker, via an output register.
// ----------------------------------------------------------------------------
module clas_back (
  input  logic           clk,
  input  logic           rst,
  input  clas_pkg::cmd_t head,
  input  logic           not_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     char_out,
  output logic           has_char,
  output logic           arg_end,
  output logic           run_overflow,
  output logic           last_of_run
);

  logic                       cur_valid;
  logic [clas_pkg::RUN_W-1:0] remaining;
  clas_pkg::tail_t            tail;
  logic [7:0]                 tail_char;
  logic                       overflow;

  logic                       out_free;
  logic                       step;
  logic                       step_last;
  logic                       in_run;

  assign out_free  = !out_valid || !out_stall;
  assign step      = cur_valid && out_free;
  assign in_run    = (remaining != '0);
  assign step_last = in_run ? ((remaining == clas_pkg::RUN_W'(1)) &&
                               (tail == clas_pkg::TAIL_NONE))
                            : 1'b1;
  // next command loads as the current one finishes its last request
  assign pop = not_empty && (!cur_valid || (step && step_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (step && step_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      remaining <= head.bs_count;
      tail      <= head.tail;
      tail_char <= head.tail_char;
      overflow  <= head.overflow;
    end else if (step && in_run) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      run_overflow <= overflow;
      last_of_run  <= step_last;
      if (in_run) begin
        char_out <= clas_pkg::CH_BSLASH;
        has_char <= 1'b1;
        arg_end  <= 1'b0;
      end else if (tail == clas_pkg::TAIL_END) begin
        char_out <= 8'h00;
        has_char <= 1'b0;
        arg_end  <= 1'b1;
      end else begin
        char_out <= tail_char;
        has_char <= 1'b1;
        arg_end  <= 1'b0;
      end
    end
  end

endmodule

/* src/command_line_argument_splitter_unit.sv */
// ----------------------------------------------------------------------------
// command_line_argument_splitter_unit
// Splits a byte stream into arguments by Windows command line rules.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle unless it stalls, and returns one
// request per argument byte or end-of-argument marker. A byte that closes
// a run of n held backslashes gives n + 1 requests, and a quote that closes
// it gives n / 2 backslashes (rounded down) plus the literal quote when n
// is odd. The back stage emits one request a cycle while out_stall is low.
// Runs themselves and separators between arguments give no request. A
// two-entry command queue lets the input keep taking bytes while the back
// stage is still emitting, and the input stalls only when that queue is
// full.
module command_line_argument_splitter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       has_char,
  output logic       arg_end,
  output logic       run_overflow,
  output logic       last_of_run
);

  logic           push;
  clas_pkg::cmd_t push_cmd;
  logic           full;
  logic           pop;
  clas_pkg::cmd_t head;
  logic           not_empty;

  clas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_in  (char_in),
    .line_end (line_end),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  clas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  clas_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_out     (char_out),
    .has_char     (has_char),
    .arg_end      (arg_end),
    .run_overflow (run_overflow),
    .last_of_run  (last_of_run)
  );

endmodule

/* bench/command_line_argument_splitter_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_line_argument_splitter_unit_test
// Self-checking bench for the argument splitter: a directed command line
// first, then random quoted and backslash-heavy lines under varying pacing,
// each result checked against a bench-side model of the splitting rules.
// ----------------------------------------------------------------------------
module command_line_argument_splitter_unit_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 370;

  typedef enum logic [1:0] {
    PACE_RX_SLOW = 2'd0,
    PACE_TX_SLOW = 2'd1,
    PACE_FULL    = 2'd2
  } pace_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    pace_t      mode;
    logic       drain_first;
    logic       hold_rx;
  } line_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       end_mark;
    logic       ovf;
    logic       last;
  } arg_piece_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic       has_char;
  logic       arg_end;
  logic       run_overflow;
  logic       last_of_run;

  line_item_t pending_q[$];
  arg_piece_t arg_out_q[$];

  // splitter state as the bench sees it
  logic                       in_arg = 1'b0;
  logic                       in_quotes = 1'b0;
  logic [clas_pkg::RUN_W-1:0] held_bs = '0;
  logic                       held_sat = 1'b0;

  pace_t rx_mode = PACE_RX_SLOW;
  logic  rx_hold_go = 1'b0;
  int    hold_left = 0;
  int    results_owed = 0;
  int    taken_n = 0;
  int    total_items = 0;
  int    gen_n = 0;
  int    results_seen = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;

  command_line_argument_splitter_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .line_end     (line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_out     (char_out),
    .has_char     (has_char),
    .arg_end      (arg_end),
    .run_overflow (run_overflow),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int idle_pct(input pace_t mode, input logic rx_side);
    case (mode)
      PACE_RX_SLOW: return rx_side ? 86 : 27;
      PACE_TX_SLOW: return rx_side ? 27 : 86;
      default:      return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_v);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want_v);
    mismatches++;
  endtask

  // works out the argument bytes and markers that one input byte causes
  function automatic void split_byte(input logic [7:0] ch, input logic fin);
    logic [clas_pkg::RUN_W-1:0] held;
    logic                       sat;
    int                         n_bs;
    int                         total;
    logic                       have_tail;
    arg_piece_t                 tail;
    arg_piece_t                 piece;
    held = held_bs;
    sat = held_sat;
    n_bs = 0;
    have_tail = 1'b0;
    tail = '0;
    if (fin) begin
      if (in_arg) begin
        // held backslashes go out literally, any open quote is dropped
        n_bs = int'(held);
        have_tail = 1'b1;
        tail.end_mark = 1'b1;
      end
      in_arg = 1'b0;
      in_quotes = 1'b0;
      held_bs = '0;
      held_sat = 1'b0;
    end else if (in_arg || (ch != clas_pkg::CH_SPACE && ch != clas_pkg::CH_TAB)) begin
      if (!in_arg) begin
        in_arg = 1'b1;
        in_quotes = 1'b0;
        held = '0;
        sat = 1'b0;
        held_bs = '0;
        held_sat = 1'b0;
      end
      if (ch == clas_pkg::CH_BSLASH) begin
        if (held_bs < clas_pkg::MAX_BACKSLASH_RUN) held_bs = held_bs + 1'b1;
        else held_sat = 1'b1;
      end else begin
        held_bs = '0;
        held_sat = 1'b0;
        if (ch == clas_pkg::CH_QUOTE) begin
          n_bs = int'(held >> 1);
          if (held[0]) begin
            have_tail = 1'b1;
            tail.ch = clas_pkg::CH_QUOTE;
            tail.has_ch = 1'b1;
          end else begin
            in_quotes = !in_quotes;
          end
        end else begin
          n_bs = int'(held);
          have_tail = 1'b1;
          if (!in_quotes && (ch == clas_pkg::CH_SPACE || ch == clas_pkg::CH_TAB)) begin
            tail.end_mark = 1'b1;
            in_arg = 1'b0;
            in_quotes = 1'b0;
          end else begin
            tail.ch = ch;
            tail.has_ch = 1'b1;
          end
        end
      end
    end
    total = n_bs + int'(have_tail);
    for (int k = 0; k < total; k++) begin
      if (k < n_bs) begin
        piece = '0;
        piece.ch = clas_pkg::CH_BSLASH;
        piece.has_ch = 1'b1;
      end else begin
        piece = tail;
      end
      piece.ovf = sat;
      piece.last = (k == total - 1);
      arg_out_q.insert(arg_out_q.size(), piece);
    end
  endfunction

  task automatic add_item(input logic [7:0] ch, input logic fin);
    line_item_t it;
    it.ch = ch;
    it.fin = fin;
    it.mode = (gen_n < 123) ? PACE_RX_SLOW : (gen_n < 246) ? PACE_TX_SLOW : PACE_FULL;
    it.drain_first = (gen_n == 123 || gen_n == 246);
    it.hold_rx = (gen_n == 90 || gen_n == 300);
    pending_q.insert(pending_q.size(), it);
    gen_n++;
  endtask

  always @(posedge clk) begin : drive_requests
    line_item_t nxt;
    logic       offer;
    logic       hold_go;
    offer = 1'b0;
    hold_go = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
      rx_hold_go <= 1'b0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0) begin
          nxt = pending_q[0];
          offer = $urandom_range(99) >= idle_pct(nxt.mode, 1'b0);
          // pause here until everything already sent has come back
          if (nxt.drain_first && (in_valid || results_owed != 0)) offer = 1'b0;
        end
        if (offer) begin
          void'(pending_q.pop_front());
          char_in <= nxt.ch;
          line_end <= nxt.fin;
          rx_mode <= nxt.mode;
          hold_go = nxt.hold_rx;
        end
        in_valid <= offer;
      end
      rx_hold_go <= hold_go;
    end
  end

  always @(posedge clk) begin : check_results
    arg_piece_t want;
    logic       stall_next;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      results_owed <= 0;
      taken_n <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        split_byte(char_in, line_end);
        taken_n <= taken_n + 1;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (arg_out_q.size() == 0) begin
          report_mismatch("unexpected result, char_out", int'(char_out), 0);
        end else begin
          want = arg_out_q.pop_front();
          if (char_out !== want.ch)
            report_mismatch("char_out", int'(char_out), int'(want.ch));
          if (has_char !== want.has_ch)
            report_mismatch("has_char", int'(has_char), int'(want.has_ch));
          if (arg_end !== want.end_mark)
            report_mismatch("arg_end", int'(arg_end), int'(want.end_mark));
          if (run_overflow !== want.ovf)
            report_mismatch("run_overflow", int'(run_overflow), int'(want.ovf));
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
        end
      end
      // long hold-off so the command queue fills and the input stalls
      if (rx_hold_go) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      stall_next = rx_hold_go || hold_left != 0 ||
                   ($urandom_range(99) < idle_pct(rx_mode, 1'b1));
      out_stall <= stall_next;
      results_owed <= arg_out_q.size();
    end
  end

  // only results that are still owed count as progress
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) ||
        (out_valid && !out_stall && results_owed != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int pick;
    int run;
    int long_runs;
    long_runs = 0;

    // directed line: separators and end between arguments, byte extremes,
    // empty quoted argument, halving and odd runs, end inside an argument
    add_item(8'hA5, 1'b1);
    add_item(clas_pkg::CH_SPACE, 1'b0);
    add_item(clas_pkg::CH_TAB, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(clas_pkg::CH_SPACE, 1'b0);
    add_item(clas_pkg::CH_QUOTE, 1'b0);
    add_item(clas_pkg::CH_QUOTE, 1'b0);
    add_item(clas_pkg::CH_TAB, 1'b0);
    add_item(clas_pkg::CH_BSLASH, 1'b0);
    add_item(clas_pkg::CH_BSLASH, 1'b0);
    add_item(clas_pkg::CH_QUOTE, 1'b0);
    add_item(clas_pkg::CH_SPACE, 1'b0);
    add_item(clas_pkg::CH_BSLASH, 1'b0);
    add_item(clas_pkg::CH_QUOTE, 1'b0);
    add_item(clas_pkg::CH_BSLASH, 1'b0);
    add_item("x", 1'b0);
    add_item(clas_pkg::CH_QUOTE, 1'b0);
    add_item(clas_pkg::CH_BSLASH, 1'b0);
    add_item(clas_pkg::CH_BSLASH, 1'b0);
    add_item(8'h5A, 1'b1);
    add_item(clas_pkg::CH_QUOTE, 1'b0);
    add_item("q", 1'b0);
    add_item(8'h00, 1'b1);

    while (gen_n < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        add_item(8'($urandom_range(255)), 1'b0);
      end else if (pick < 40) begin
        add_item($urandom_range(1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB, 1'b0);
      end else if (pick < 53) begin
        add_item(clas_pkg::CH_QUOTE, 1'b0);
      end else if (pick < 80) begin
        // backslash run, occasionally past the saturation bound
        if (pick < 55 && long_runs < 3 && gen_n < ITEM_TARGET - 80) begin
          run = $urandom_range(clas_pkg::MAX_BACKSLASH_RUN - 4,
                               clas_pkg::MAX_BACKSLASH_RUN + 6);
          long_runs++;
        end else begin
          run = $urandom_range(1, 5);
        end
        repeat (run) add_item(clas_pkg::CH_BSLASH, 1'b0);
        case ($urandom_range(3))
          0:       add_item(clas_pkg::CH_QUOTE, 1'b0);
          1:       add_item(8'($urandom_range(255)), 1'b0);
          2:       add_item($urandom_range(1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB, 1'b0);
          default: add_item(8'($urandom_range(255)), 1'b1);
        endcase
      end else if (pick < 91) begin
        add_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      end else if (pick < 96) begin
        add_item(8'($urandom_range(255)), 1'b1);
      end else begin
        add_item(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    total_items = pending_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (taken_n != total_items || results_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (arg_out_q.size() != 0) report_mismatch("results never produced", 0, arg_out_q.size());
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/clas_pkg.sv
src/clas_front.sv
src/clas_queue.sv
src/clas_back.sv
src/command_line_argument_splitter_unit.sv
bench/command_line_argument_splitter_unit_test.sv
